// File: rtl/hcbd_pkg.sv
// types and constants shared by the chunked body decoder
package hcbd_pkg;

	// one byte of response text with its framing marks
	typedef struct packed {
		logic [7:0] byte_in;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	// one result: payload byte or end-of-body report
	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [31:0] body_total;
		logic        ended_by_zero_chunk;
		logic        last;
	} out_item_t;

	// parse modes
	localparam logic [1:0] MODE_HEADER = 2'd0;
	localparam logic [1:0] MODE_LINE   = 2'd1;
	localparam logic [1:0] MODE_DATA   = 2'd2;
	localparam logic [1:0] MODE_DONE   = 2'd3;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	// line framing characters
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;

	// reset value of the capacity register
	localparam logic [31:0] CAPACITY_RESET = 32'd4096;

	// result queue geometry
	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_AW    = 3;

endpackage

// File: rtl/http_chunked_body_decoder.sv
// http chunked transfer decoder: header skip, size lines, payload and end report
//
// Takes one response byte per in transfer and returns decoded chunk payload
// bytes and at most one end-of-body report per response on the out channel. The
// header is skipped up to the first CR LF CR LF; each following size line
// gives its value from up to MAX_HEX_DIGITS leading hex digits, the rest of
// the line being ignored, and empty lines are skipped. A zero size line or
// the byte marked last_byte ends the body with a report carrying the
// saturated sum of chunk sizes. Payload beyond capacity_q bytes per
// response is dropped but still counted. Rate: one byte per clock cycle in
// while the result queue has room; the out channel moves one result per cycle
// while out_ready is high, and a payload byte that is also the last byte
// gives two results, so the sustained figure is one byte per cycle as long as
// such bytes are rare. An in transfer passes one input register, then the parse
// state update, whose results go into an eight-entry result queue that takes
// new bytes while earlier results wait for out_ready. The capacity register
// takes a cfg transfer in any cycle and should be written only while idle.
module http_chunked_body_decoder #(
	parameter int MAX_HEX_DIGITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// byte input
	input  logic                in_valid,
	output logic                in_ready,
	input  hcbd_pkg::in_item_t  in_item,
	// result output
	output logic                out_valid,
	input  logic                out_ready,
	output hcbd_pkg::out_item_t out_item,
	// capacity register write
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_data
);

	// digit counter holds 0..MAX_HEX_DIGITS
	localparam int DCW = $clog2(MAX_HEX_DIGITS + 1);
	localparam logic [DCW-1:0] DIGIT_MAX = DCW'(MAX_HEX_DIGITS);
	localparam int QCW = hcbd_pkg::QUEUE_AW + 1;

	// hex decode: {valid, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// capacity register
	logic [31:0] capacity_q;

	// input register
	logic               valid_s1;
	hcbd_pkg::in_item_t item_s1;

	// parse state
	logic [1:0]     mode_q;
	logic [1:0]     hmatch_q;
	logic [31:0]    accum_q;
	logic [DCW-1:0] dcount_q;
	logic           has_text_q;
	logic           seen_cr_q;
	logic [31:0]    remaining_q;
	logic [31:0]    emitted_q;
	logic [31:0]    total_q;

	// next state
	logic [1:0]     mode_d;
	logic [1:0]     hmatch_d;
	logic [31:0]    accum_d;
	logic [DCW-1:0] dcount_d;
	logic           has_text_d;
	logic           seen_cr_d;
	logic [31:0]    remaining_d;
	logic [31:0]    emitted_d;
	logic [31:0]    total_d;

	// results of the current byte
	hcbd_pkg::out_item_t res0, res1;
	logic [1:0]          res_n;

	logic [7:0]  c;
	logic [4:0]  hex;
	logic [32:0] sum;

	// result queue
	hcbd_pkg::out_item_t               queue_q [hcbd_pkg::QUEUE_DEPTH];
	logic [hcbd_pkg::QUEUE_AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]                    count_q;
	logic [QCW-1:0]                    reserve;
	logic                              pop;
	logic [1:0]                        push_n;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= hcbd_pkg::CAPACITY_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	// room for the byte in flight and this one, two results each
	assign reserve  = valid_s1 ? QCW'(4) : QCW'(2);
	assign in_ready = (count_q + reserve) <= QCW'(hcbd_pkg::QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	assign c   = item_s1.byte_in;
	assign hex = hex_decode(c);
	// a size line only closes without first_byte, so the stored values apply
	assign sum = {1'b0, total_q} + {1'b0, accum_q};

	// parse step for the registered byte
	always_comb begin
		mode_d      = mode_q;
		hmatch_d    = hmatch_q;
		accum_d     = accum_q;
		dcount_d    = dcount_q;
		has_text_d  = has_text_q;
		seen_cr_d   = seen_cr_q;
		remaining_d = remaining_q;
		emitted_d   = emitted_q;
		total_d     = total_q;
		res0        = '0;
		res1        = '0;
		res_n       = 2'd0;

		// start of a new response
		if (item_s1.first_byte) begin
			mode_d      = hcbd_pkg::MODE_HEADER;
			hmatch_d    = 2'd0;
			accum_d     = '0;
			dcount_d    = '0;
			has_text_d  = 1'b0;
			seen_cr_d   = 1'b0;
			remaining_d = '0;
			emitted_d   = '0;
			total_d     = '0;
		end

		case (mode_d)
			hcbd_pkg::MODE_HEADER: begin
				// crlfcrlf: even positions want cr, odd want lf
				if (c == (hmatch_d[0] ? hcbd_pkg::CH_LF : hcbd_pkg::CH_CR)) begin
					if (hmatch_d == 2'd3) begin
						hmatch_d   = 2'd0;
						mode_d     = hcbd_pkg::MODE_LINE;
						accum_d    = '0;
						dcount_d   = '0;
						has_text_d = 1'b0;
						seen_cr_d  = 1'b0;
					end else begin
						hmatch_d = hmatch_d + 2'd1;
					end
				end else begin
					hmatch_d = (c == hcbd_pkg::CH_CR) ? 2'd1 : 2'd0;
				end
			end
			hcbd_pkg::MODE_LINE: begin
				if (seen_cr_d && c == hcbd_pkg::CH_LF) begin
					if (!has_text_d) begin
						// empty line
						accum_d    = '0;
						dcount_d   = '0;
						has_text_d = 1'b0;
						seen_cr_d  = 1'b0;
					end else if (accum_d == '0) begin
						// zero size line ends the body
						res0.kind                = hcbd_pkg::KIND_REPORT;
						res0.body_total          = total_d;
						res0.ended_by_zero_chunk = 1'b1;
						res_n                    = 2'd1;
						mode_d                   = hcbd_pkg::MODE_DONE;
					end else begin
						total_d     = sum[32] ? 32'hffff_ffff : sum[31:0];
						remaining_d = accum_d;
						mode_d      = hcbd_pkg::MODE_DATA;
						accum_d     = '0;
						dcount_d    = '0;
						has_text_d  = 1'b0;
						seen_cr_d   = 1'b0;
					end
				end else begin
					// a lone cr is line text and stops digit collection
					if (seen_cr_d) begin
						seen_cr_d  = 1'b0;
						dcount_d   = DIGIT_MAX;
						has_text_d = 1'b1;
					end
					if (c == hcbd_pkg::CH_CR) begin
						seen_cr_d = 1'b1;
					end else begin
						if (hex[4] && dcount_d < DIGIT_MAX) begin
							accum_d  = {accum_d[27:0], hex[3:0]};
							dcount_d = dcount_d + DCW'(1);
						end else if (!hex[4]) begin
							dcount_d = DIGIT_MAX;
						end
						has_text_d = 1'b1;
					end
				end
			end
			hcbd_pkg::MODE_DATA: begin
				if (emitted_d < capacity_q) begin
					res0.kind      = hcbd_pkg::KIND_PAYLOAD;
					res0.data_byte = c;
					res_n          = 2'd1;
					emitted_d      = emitted_d + 32'd1;
				end
				remaining_d = remaining_d - 32'd1;
				if (remaining_d == '0) begin
					mode_d     = hcbd_pkg::MODE_LINE;
					accum_d    = '0;
					dcount_d   = '0;
					has_text_d = 1'b0;
					seen_cr_d  = 1'b0;
				end
			end
			default: begin
				// body done: ignore bytes until the next response
			end
		endcase

		// input ran out before the body ended
		if (item_s1.last_byte && mode_d != hcbd_pkg::MODE_DONE) begin
			if (res_n == 2'd0) begin
				res0.kind       = hcbd_pkg::KIND_REPORT;
				res0.body_total = total_d;
			end else begin
				res1.kind       = hcbd_pkg::KIND_REPORT;
				res1.body_total = total_d;
			end
			res_n  = res_n + 2'd1;
			mode_d = hcbd_pkg::MODE_DONE;
		end

		// mark the final result of this byte
		if (res_n == 2'd1)
			res0.last = 1'b1;
		else if (res_n == 2'd2)
			res1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= hcbd_pkg::MODE_HEADER;
			hmatch_q    <= 2'd0;
			accum_q     <= '0;
			dcount_q    <= '0;
			has_text_q  <= 1'b0;
			seen_cr_q   <= 1'b0;
			remaining_q <= '0;
			emitted_q   <= '0;
			total_q     <= '0;
		end else if (valid_s1) begin
			mode_q      <= mode_d;
			hmatch_q    <= hmatch_d;
			accum_q     <= accum_d;
			dcount_q    <= dcount_d;
			has_text_q  <= has_text_d;
			seen_cr_q   <= seen_cr_d;
			remaining_q <= remaining_d;
			emitted_q   <= emitted_d;
			total_q     <= total_d;
		end
	end

	// result queue: up to two writes, one read per cycle
	assign push_n    = valid_s1 ? res_n : 2'd0;
	assign out_valid = count_q != '0;
	assign out_item  = queue_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			queue_q[wr_ptr_q] <= res0;
		if (push_n == 2'd2)
			queue_q[wr_ptr_q + hcbd_pkg::QUEUE_AW'(1)] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + hcbd_pkg::QUEUE_AW'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + hcbd_pkg::QUEUE_AW'(1);
			count_q <= count_q + QCW'(push_n) - QCW'(pop);
		end
	end

endmodule

// File: bench/tb_http_chunked_body_decoder.sv
// testbench for the http chunked body decoder: response bytes in, payload bytes and end reports out
module tb_http_chunked_body_decoder;
	import hcbd_pkg::*;

	localparam int SIZE_DIGITS_MAX  = 8;
	// the block answers after its input register and parse step, so these cover any work still in flight
	localparam int DRAIN_CYCLES     = 8;
	// slowest run: bytes that give two results each, the receiver in its choked pattern,
	// plus sender gaps and drain pauses, stays well under the limit
	localparam int CYCLE_LIMIT      = 400000;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int FINAL_WAIT_MAX   = 5000;

	// receiver behavior, picked anew at random whenever the current pattern's run ends
	typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_pattern_e;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_item_t    in_item   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data  = '0;

	http_chunked_body_decoder #(
		.MAX_HEX_DIGITS(SIZE_DIGITS_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// decoder state as the bench sees it
	// ------------------------------------------------------------------
	logic [1:0]  cur_mode         = MODE_HEADER;
	logic [1:0]  crlf_progress    = '0;   // how far into CR LF CR LF the header scan is
	logic [31:0] size_value       = '0;   // value built from the leading hex digits
	logic [3:0]  size_digits      = '0;   // digits taken, or the max once a non-digit is seen
	logic        line_nonempty    = 1'b0;
	logic        cr_held          = 1'b0; // a CR waits to see whether LF follows
	logic [31:0] chunk_bytes_left = '0;
	logic [31:0] payload_sent     = '0;   // payload bytes emitted in this response
	logic [31:0] chunk_total      = '0;   // saturating sum of chunk sizes
	logic [31:0] capacity_limit   = CAPACITY_RESET;

	// results still owed by the block, oldest first
	out_item_t decoded_results[$];

	int unsigned error_count = 0;
	int unsigned cycles_run  = 0;
	int unsigned bytes_sent  = 0;

	function automatic int hex_digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return int'(c - "0");
		end
		if (c >= "a" && c <= "f") begin
			return int'(c - "a") + 10;
		end
		if (c >= "A" && c <= "F") begin
			return int'(c - "A") + 10;
		end
		return -1;
	endfunction

	function automatic out_item_t make_result(input logic kind, input logic [7:0] data,
			input logic [31:0] total, input logic zero_end);
		out_item_t r;
		r.kind                = kind;
		r.data_byte           = data;
		r.body_total          = total;
		r.ended_by_zero_chunk = zero_end;
		r.last                = 1'b0;
		return r;
	endfunction

	task automatic clear_size_line();
		size_value    = '0;
		size_digits   = '0;
		line_nonempty = 1'b0;
		cr_held       = 1'b0;
	endtask

	task automatic clear_response_state();
		cur_mode         = MODE_HEADER;
		crlf_progress    = '0;
		chunk_bytes_left = '0;
		payload_sent     = '0;
		chunk_total      = '0;
		clear_size_line();
	endtask

	// ordinary text of a size line: digits build the value until the first non-digit
	task automatic absorb_line_char(input logic [7:0] c);
		int h;
		h = hex_digit_value(c);
		if (h >= 0 && size_digits < SIZE_DIGITS_MAX) begin
			size_value  = {size_value[27:0], h[3:0]};
			size_digits = size_digits + 4'd1;
		end else if (h < 0) begin
			size_digits = 4'(SIZE_DIGITS_MAX);
		end
		line_nonempty = 1'b1;
	endtask

	// advance the parse by one accepted byte and queue the results it causes
	task automatic decode_byte(input in_item_t item);
		out_item_t   found[2];
		int          n;
		logic [7:0]  c;
		logic [32:0] sum;
		n = 0;
		c = item.byte_in;
		if (item.first_byte) begin
			clear_response_state();
		end
		case (cur_mode)
			MODE_HEADER: begin
				// pattern is CR on even steps, LF on odd steps
				if (c == (crlf_progress[0] ? CH_LF : CH_CR)) begin
					if (crlf_progress == 2'd3) begin
						crlf_progress = '0;
						cur_mode      = MODE_LINE;
						clear_size_line();
					end else begin
						crlf_progress = crlf_progress + 2'd1;
					end
				end else begin
					crlf_progress = (c == CH_CR) ? 2'd1 : 2'd0;
				end
			end
			MODE_LINE: begin
				if (cr_held && c == CH_LF) begin
					if (!line_nonempty) begin
						clear_size_line();
					end else if (size_value == 0) begin
						found[n] = make_result(KIND_REPORT, 8'd0, chunk_total, 1'b1);
						n++;
						cur_mode = MODE_DONE;
					end else begin
						sum              = {1'b0, chunk_total} + {1'b0, size_value};
						chunk_total      = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
						chunk_bytes_left = size_value;
						cur_mode         = MODE_DATA;
						clear_size_line();
					end
				end else begin
					// a CR without LF becomes line text
					if (cr_held) begin
						cr_held = 1'b0;
						absorb_line_char(CH_CR);
					end
					if (c == CH_CR) begin
						cr_held = 1'b1;
					end else begin
						absorb_line_char(c);
					end
				end
			end
			MODE_DATA: begin
				if (payload_sent < capacity_limit) begin
					found[n] = make_result(KIND_PAYLOAD, c, 32'd0, 1'b0);
					n++;
					payload_sent = payload_sent + 32'd1;
				end
				chunk_bytes_left = chunk_bytes_left - 32'd1;
				if (chunk_bytes_left == 0) begin
					cur_mode = MODE_LINE;
					clear_size_line();
				end
			end
			default: ;
		endcase
		if (item.last_byte && cur_mode != MODE_DONE) begin
			found[n] = make_result(KIND_REPORT, 8'd0, chunk_total, 1'b0);
			n++;
			cur_mode = MODE_DONE;
		end
		if (n > 0) begin
			found[n - 1].last = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			decoded_results.push_back(found[i]);
		end
	endtask

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	function automatic string format_result(input out_item_t r);
		return $sformatf("kind=%0d data=%02h total=%08h zero_end=%0d last=%0d",
			r.kind, r.data_byte, r.body_total, r.ended_by_zero_chunk, r.last);
	endfunction

	task automatic note_mismatch(input string what, input out_item_t want, input out_item_t got);
		error_count++;
		if (error_count <= SHOWN_MISMATCHES) begin
			$display("mismatch (%s) at cycle %0d", what, cycles_run);
			$display("  expected %s", format_result(want));
			$display("  actual   %s", format_result(got));
		end
	endtask

	task automatic match_result(input out_item_t got);
		out_item_t want;
		if (decoded_results.size() == 0) begin
			note_mismatch("no result was due", '0, got);
			return;
		end
		want = decoded_results.pop_front();
		if (got.kind !== want.kind || got.data_byte !== want.data_byte
				|| got.body_total !== want.body_total
				|| got.ended_by_zero_chunk !== want.ended_by_zero_chunk
				|| got.last !== want.last) begin
			note_mismatch("field differs", want, got);
		end
	endtask

	// receiver: checks each out transfer, then picks out_ready by the current pattern
	rx_pattern_e rx_pattern      = RX_OPEN;
	int          rx_pattern_left = 0;
	int unsigned rx_tick         = 0;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			match_result(out_item);
		end
		if (rx_pattern_left == 0) begin
			rx_pattern      = rx_pattern_e'($urandom_range(0, 3));
			rx_pattern_left = $urandom_range(16, 256);
		end
		rx_pattern_left--;
		rx_tick++;
		case (rx_pattern)
			RX_OPEN:     out_ready <= 1'b1;
			RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: out_ready <= ((rx_tick % 7) < 3);
			default:     out_ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// run limit
	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------
	int burst_left    = 0;
	bit sender_steady = 1'b0;   // when set, bursts follow each other with no gap

	// one in transfer; valid is left high so the next call can follow without a bubble
	task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
		in_item_t item;
		int       gap;
		item.byte_in    = b;
		item.first_byte = first;
		item.last_byte  = last;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap        = sender_steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_item  <= item;
		do @(posedge clk); while (!in_ready);
		decode_byte(item);
		burst_left--;
		bytes_sent++;
	endtask

	// "\015" is CR throughout
	task automatic send_text(input string s, input logic first, input logic last);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], first && i == 0, last && i == s.len() - 1);
		end
	endtask

	// hold the input until every owed result is out and the pipeline has settled
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (decoded_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [31:0] value);
		pause_until_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity_limit = value;
	endtask

	// ------------------------------------------------------------------
	// random response builder
	// ------------------------------------------------------------------
	logic [7:0] response_text[$];

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10) begin
			return "0" + v;
		end
		return (upper ? "A" : "a") + (v - 4'd10);
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			response_text.push_back(s[i]);
		end
	endtask

	task automatic add_random_payload(input int unsigned count);
		repeat (count) response_text.push_back(8'($urandom_range(0, 255)));
	endtask

	// size line with optional empty line before, leading zeros and an extension after
	task automatic add_size_line(input int unsigned chunk_len);
		bit upper;
		int nd;
		int pad;
		upper = 1'($urandom_range(0, 1));
		nd    = 1;
		while (nd < SIZE_DIGITS_MAX && (chunk_len >> (4 * nd)) != 0) nd++;
		pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		if (pad > SIZE_DIGITS_MAX - nd) begin
			pad = SIZE_DIGITS_MAX - nd;
		end
		if ($urandom_range(0, 5) == 0) begin
			add_text("\015\n");
		end
		repeat (pad) response_text.push_back("0");
		for (int i = nd - 1; i >= 0; i--) begin
			response_text.push_back(hex_char(4'((chunk_len >> (4 * i)) & 15), upper));
		end
		case ($urandom_range(0, 7))
			0: add_text(";ext=1");
			1: add_text(" ");
			2: add_text(";a\015b");   // lone CR inside the extension
			default: ;
		endcase
		add_text("\015\n");
	endtask

	task automatic build_response();
		int unsigned chunk_len;
		int          spot;
		response_text.delete();
		// header lines with stray CR and LF mixed in
		repeat ($urandom_range(0, 12)) begin
			case ($urandom_range(0, 7))
				0: add_text("\015\n");
				1: response_text.push_back(CH_CR);
				2: response_text.push_back(CH_LF);
				default: response_text.push_back(8'($urandom_range(32, 126)));
			endcase
		end
		add_text("\015\n\015\n");
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 9))
				0: chunk_len = 1;
				1, 2, 3, 4, 5, 6: chunk_len = $urandom_range(1, 16);
				7, 8: chunk_len = $urandom_range(17, 64);
				default: chunk_len = $urandom_range(65, 200);
			endcase
			add_size_line(chunk_len);
			add_random_payload(chunk_len);
			add_text("\015\n");
		end
		add_size_line(0);
		add_text("\015\n");
		// now and then a damaged byte somewhere in the response
		if ($urandom_range(0, 9) == 0) begin
			spot = $urandom_range(0, response_text.size() - 1);
			response_text[spot] = 8'($urandom_range(0, 255));
		end
	endtask

	// a built response, sometimes cut short by last_byte, sometimes left open
	task automatic send_response();
		int stop;
		bit mark_last;
		build_response();
		stop      = response_text.size() - 1;
		mark_last = 1'b1;
		case ($urandom_range(0, 9))
			0, 1, 2: stop = $urandom_range(0, response_text.size() - 1);
			3, 4: mark_last = 1'b0;
			default: ;
		endcase
		for (int i = 0; i <= stop; i++) begin
			send_byte(response_text[i], i == 0, mark_last && i == stop);
		end
	endtask

	// loose bytes with random framing marks
	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 24)) begin
			case ($urandom_range(0, 3))
				0: b = CH_CR;
				1: b = CH_LF;
				default: b = 8'($urandom_range(0, 255));
			endcase
			send_byte(b, $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// one chunk at the reset capacity, then a zero size line
	task automatic test_basic_chunk();
		send_text("X\015\n\015\n2\015\nhi\015\n0\015\n", 1'b1, 1'b0);
	endtask

	// empty line skipped, upper and lower case sizes, extension, extreme payload values,
	// zero size line ending on the last byte
	task automatic test_hex_forms();
		logic [7:0] extremes[10];
		extremes = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h0D, 8'h0A};
		send_text("\015\n\015\n\015\nA;e\015\n", 1'b1, 1'b0);
		foreach (extremes[i]) begin
			send_byte(extremes[i], 1'b0, 1'b0);
		end
		send_text("\015\nb\015\n", 1'b0, 1'b0);
		repeat (11) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		send_text("\015\n0\015\n", 1'b0, 1'b1);
	endtask

	// nine digits, the ninth ignored; then a line with no digits ends the body
	task automatic test_long_size_line();
		send_text("\015\n\015\n000000010\015\nZ\015\nzz\015\n", 1'b1, 1'b0);
	endtask

	// CR without LF counts as line text; the last byte is payload
	task automatic test_lone_cr();
		send_text("\015\n\015\n1\015q\015\nP", 1'b1, 1'b1);
	endtask

	// input runs out inside the header, partly through the CR LF CR LF
	task automatic test_cut_in_header();
		send_text("AB\015\n\015", 1'b1, 1'b1);
	endtask

	// bytes after the body has ended are ignored, the last byte included
	task automatic test_input_after_end();
		send_text("\015\n\015\n0\015\n5\015\nabcde", 1'b1, 1'b1);
	endtask

	// largest size value, cut off by the last byte
	task automatic test_largest_total();
		send_text("\015\n\015\nFFFFFFFF\015\nxy", 1'b1, 1'b1);
	endtask

	// no payload at all, a clipped chunk, then no limit
	task automatic test_capacity_limits();
		logic [31:0] limits[3];
		limits = '{32'd0, 32'd2, 32'hFFFF_FFFF};
		foreach (limits[i]) begin
			write_capacity(limits[i]);
			send_text("\015\n\015\n3\015\nabc\015\n0\015\n", 1'b1, 1'b0);
		end
	endtask

	// phases of random responses and noise, one capacity per phase
	task automatic test_random_traffic();
		logic [31:0] limits[6];
		int unsigned target;
		limits = '{CAPACITY_RESET, 32'd0, 32'd1, 32'd9, 32'hFFFF_FFFF,
			32'($urandom_range(2, 40))};
		foreach (limits[p]) begin
			write_capacity(limits[p]);
			sender_steady = (p == 4);
			target        = bytes_sent + 50;
			while (bytes_sent < target) begin
				if ($urandom_range(0, 7) == 0) begin
					send_noise();
				end else begin
					send_response();
				end
				if ($urandom_range(0, 11) == 0) begin
					pause_until_drained();
				end
			end
		end
		sender_steady = 1'b0;
	endtask

	initial begin
		int final_wait;
		final_wait = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_chunk();
		test_hex_forms();
		test_long_size_line();
		test_lone_cr();
		test_cut_in_header();
		test_input_after_end();
		test_largest_total();
		test_capacity_limits();
		test_random_traffic();

		// let every owed result come out, then watch a little longer for strays
		in_valid <= 1'b0;
		while (decoded_results.size() != 0 && final_wait < FINAL_WAIT_MAX) begin
			@(posedge clk);
			final_wait++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (decoded_results.size() != 0) begin
			error_count += decoded_results.size();
			$display("%0d results never arrived", decoded_results.size());
		end
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
